// ===== src/bba_pkg.sv =====
// Block bitmap allocator: shared types, constants and codes.
// No dependencies; imported by every module of the allocator except bba_ram.
package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int MAX_GROUPS = 8;

    localparam int WORD_W = 64;
    localparam int WORDS  = MAX_BLOCKS / WORD_W;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int IDX_W  = 12;
    localparam int GRP_W  = 3;
    localparam int CNT_W  = 13;
    localparam int GCFG_W = 4;
    localparam int CFG_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W = $clog2(GRP_W);
    localparam int DIV_W  = CNT_W + GRP_W;
    localparam int PROD_W = CNT_W + GCFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_GROUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT      = 1'b1;

    localparam logic [CNT_W-1:0]  BPG_RESET    = 13'd512;
    localparam logic [GCFG_W-1:0] GROUPS_RESET = 4'd8;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DIV_GO,
        S_DIV,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t              operation;
        logic [IDX_W-1:0] block_index;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic [GRP_W-1:0] group_of_block;
        status_t          status;
        logic [CNT_W-1:0] free_total;
    } out_beat_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } bba_mem_req_t;

endpackage

// ===== src/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bba_bitmap.sv =====
// Used-bit bitmap: one RAM word per 64 blocks plus per-word written flags.
// Depends on bba_pkg and bba_ram. A word never written reads as all free.
module bba_bitmap
    import bba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bba_mem_req_t      req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORDS-1:0]  written_reg;
    logic              rd_written_reg;
    logic [WORD_W-1:0] ram_q;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rd_written_reg ? ram_q : '0;

endmodule

// ===== src/bba_grp_div.sv =====
// Group number of a block: restoring divide, one quotient bit per cycle.
// Depends on bba_pkg. Quotient is known to fit GRP_W bits.
module bba_grp_div
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [GRP_W-1:0] quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [GRP_W-1:0]  quot_reg;
    logic [DIV_W-1:0]  trial;
    logic              fits;

    assign trial = DIV_W'(divisor) << step_reg;
    assign fits  = rem_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(GRP_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DIV_W'(dividend);
            quot_reg <= '0;
        end
        else if (busy_reg && fits)
        begin
            rem_reg  <= rem_reg - trial;
            quot_reg <= quot_reg | (GRP_W'(1) << step_reg);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== src/block_bitmap_allocator_core.sv =====
// Block bitmap allocator top: request sequencer, counts and result register.
// Depends on bba_pkg, bba_bitmap and bba_grp_div.
//
//  channel | signals                        | beat
//  req     | req_valid, req_ready, req_data | in_beat_t: operation, block_index
//  rsp     | rsp_valid, rsp_ready, rsp_data | out_beat_t: index, group, status, free
//  cfg     | cfg_we, cfg_index, cfg_data    | register write, no handshake
//
// One request at a time; the sequencer returns to idle before the next request. Allocate
// scans bitmap words in order, one RAM read per cycle, to the word with the first free
// block; full: all words, words = capacity/64 rounded up. Free: read word, clear bit; an
// out-of-range free skips both and the divider. Group number: start, 3 bits, done.
// Reset frees every block at once through per-word flags; no clearing pass.
// A held result does not block the next request; a finished one waits for rsp_ready.
module block_bitmap_allocator_core
    import bba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  in_beat_t             req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output out_beat_t            rsp_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  bpg_reg;
    logic [GCFG_W-1:0] groups_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W:0]   rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] ev_ptr_reg, ev_ptr_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [GRP_W-1:0]  res_grp_reg, res_grp_next;
    status_t           res_st_reg, res_st_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    out_beat_t         out_reg, out_next;
    logic              out_vld_reg, out_vld_next;

    logic [CNT_W-1:0]  eff_bpg;
    logic [GCFG_W-1:0] eff_grp;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  cap_up;
    logic [ADDR_W:0]   nwords;
    logic [WORD_W-1:0] keep_mask;
    logic              ev_last;
    logic [WORD_W-1:0] scan_word;
    logic              fz_found;
    logic [BIT_W-1:0]  fz_pos;
    logic [WORD_W-1:0] mem_rdata;
    bba_mem_req_t      mem_req;
    logic              div_start;
    logic              div_done;
    logic [GRP_W-1:0]  div_quot;
    logic [CNT_W-1:0]  free_total;
    logic              clr_bit;

    function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

    bba_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    bba_grp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (res_idx_reg),
        .divisor  (eff_bpg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // capacity and scan limits
    assign eff_bpg = (bpg_reg == '0) ? CNT_W'(1) : bpg_reg;

    always_comb
    begin
        if (groups_reg == '0)
        begin
            eff_grp = GCFG_W'(1);
        end
        else if (groups_reg > GCFG_W'(MAX_GROUPS))
        begin
            eff_grp = GCFG_W'(MAX_GROUPS);
        end
        else
        begin
            eff_grp = groups_reg;
        end
    end

    assign prod      = PROD_W'(eff_bpg) * PROD_W'(eff_grp);
    assign cap       = (prod > PROD_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : prod[CNT_W-1:0];
    assign cap_up    = cap + CNT_W'(WORD_W - 1);
    assign nwords    = cap_up[CNT_W-1:BIT_W];
    assign keep_mask = (cap[BIT_W-1:0] == '0) ? '1
                     : ((WORD_W'(1) << cap[BIT_W-1:0]) - WORD_W'(1));
    assign ev_last   = ({1'b0, ev_ptr_reg} == (nwords - (ADDR_W + 1)'(1)));
    assign scan_word = mem_rdata | (ev_last ? ~keep_mask : '0);
    assign {fz_found, fz_pos} = first_zero(scan_word);
    assign clr_bit    = mem_rdata[idx_reg[BIT_W-1:0]];
    assign free_total = (cap > used_reg) ? (cap - used_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bpg_reg     <= BPG_RESET;
            groups_reg  <= GROUPS_RESET;
            used_reg    <= '0;
            out_vld_reg <= 1'b0;
            ev_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            out_vld_reg <= out_vld_next;
            ev_vld_reg  <= ev_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BLOCKS_PER_GROUP: bpg_reg    <= cfg_data;
                    CFG_GROUP_COUNT:      groups_reg <= cfg_data[GCFG_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        rd_ptr_reg  <= rd_ptr_next;
        ev_ptr_reg  <= ev_ptr_next;
        res_idx_reg <= res_idx_next;
        res_grp_reg <= res_grp_next;
        res_st_reg  <= res_st_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rd_ptr_next  = rd_ptr_reg;
        ev_ptr_next  = ev_ptr_reg;
        ev_vld_next  = 1'b0;
        res_idx_next = res_idx_reg;
        res_grp_next = res_grp_reg;
        res_st_next  = res_st_reg;
        used_next    = used_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !rsp_ready;
        mem_req      = '0;
        div_start    = 1'b0;
        req_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                res_grp_next = '0;
                res_st_next  = ST_OK;
                rd_ptr_next  = '0;
                if (req_valid)
                begin
                    idx_next   = req_data.block_index;
                    state_next = (req_data.operation == OP_ALLOC) ? S_SCAN : S_FREE_RD;
                end
            end

            S_SCAN:
            begin
                // read word rd_ptr while checking the word read last cycle
                if (rd_ptr_reg < nwords)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.rd_addr = rd_ptr_reg[ADDR_W-1:0];
                    rd_ptr_next     = rd_ptr_reg + 1'b1;
                    ev_ptr_next     = rd_ptr_reg[ADDR_W-1:0];
                    ev_vld_next     = 1'b1;
                end
                if (ev_vld_reg && fz_found)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ev_ptr_reg;
                    mem_req.wr_data = mem_rdata | (WORD_W'(1) << fz_pos);
                    res_idx_next    = {ev_ptr_reg, fz_pos};
                    if (used_reg != '1)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    ev_vld_next = 1'b0;
                    state_next  = S_DIV_GO;
                end
                else if (ev_vld_reg && ev_last)
                begin
                    res_idx_next = '0;
                    res_st_next  = ST_FULL;
                    ev_vld_next  = 1'b0;
                    state_next   = S_RESP;
                end
            end

            S_FREE_RD:
            begin
                res_idx_next = idx_reg;
                if (CNT_W'(idx_reg) >= cap)
                begin
                    res_st_next = ST_RANGE;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg[IDX_W-1:BIT_W];
                    state_next      = S_FREE_WR;
                end
            end

            S_FREE_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[IDX_W-1:BIT_W];
                mem_req.wr_data = mem_rdata & ~(WORD_W'(1) << idx_reg[BIT_W-1:0]);
                if (clr_bit && (used_reg != '0))
                begin
                    used_next = used_reg - 1'b1;
                end
                state_next = S_DIV_GO;
            end

            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_grp_next = div_quot;
                    state_next   = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_vld_reg || rsp_ready)
                begin
                    out_next.result_index   = res_idx_reg;
                    out_next.group_of_block = res_grp_reg;
                    out_next.status         = res_st_reg;
                    out_next.free_total     = free_total;
                    out_vld_next            = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_reg;

    a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
        else $error("bitmap read and write hit the same word");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_BLOCKS))
        else $error("used count above bitmap size");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_FULL
        |-> rsp_data.result_index == '0 && rsp_data.group_of_block == '0)
        else $error("full result carries a block index");

endmodule
